// ===== src/cap_pkg.sv =====
// Shared types, constants and helpers for the capsule support and bounds pipeline.
package cap_pkg;

  // coordinate and operand widths
  localparam int CW  = 32;              // coordinate width, signed Q16.16
  localparam int QW  = 16;              // quaternion component width, Q1.14
  localparam int RW  = 31;              // radius / half_height register width
  localparam int CIW = 1;               // register index width

  // register indexes
  localparam logic [CIW-1:0] REG_RADIUS      = 1'd0;
  localparam logic [CIW-1:0] REG_HALF_HEIGHT = 1'd1;

  localparam logic [RW-1:0] RADIUS_RST      = 31'd65536;
  localparam logic [RW-1:0] HALF_HEIGHT_RST = 31'd65536;

  // axis in Q.28, magnitude up to 2^32
  localparam int AX_FRAC = 2 * (QW - 2);
  localparam int AXW     = 2 * QW + 2;
  localparam int AMW     = AXW - 1;
  localparam logic [AXW-1:0] AX_ONE = AXW'(1) << AX_FRAC;

  // half_height * |axis| product and Q16.16 offset
  localparam int PRW = RW + AMW;
  localparam int OFW = PRW - AX_FRAC;
  localparam logic [PRW-1:0] OFF_RND = PRW'(1) << (AX_FRAC - 1);

  // working width for endpoints and box, before saturation
  localparam int EW = ((CW > OFW) ? CW : OFW) + 3;

  // dot product split of the direction
  localparam int DLO = CW / 2;
  localparam int DHW = CW - DLO;
  localparam int DTW = OFW + CW + 2;

  // normalized direction, sum of squares, length
  localparam int NW   = 30;
  localparam int SQW  = 2 * NW + 2;
  localparam int LW   = SQW / 2;
  localparam int RMW  = LW + 3;

  // divider: numerator radius*e + len/2, quotient bound from len >= 2^(NW-1)
  localparam int NUMW = RW + NW + 1;
  localparam int QTW  = NUMW - (NW - 1);
  localparam int DRW  = LW + 1;

  // saturation bounds
  localparam logic signed [EW-1:0] CMAX = $signed({{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [EW-1:0] CMIN = $signed({{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}});

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] support_x;
    logic signed [CW-1:0] support_y;
    logic signed [CW-1:0] support_z;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;
    logic                 zero_direction;
  } out_t;

  // geometry that rides along the length and divide pipelines
  typedef struct packed {
    logic [SQW-1:0]       sum;
    logic [2:0][NW-1:0]   e;
    logic [2:0]           neg;
    logic                 zero;
    logic [2:0][EW-1:0]   pt;
    logic [2:0][EW-1:0]   lo;
    logic [2:0][EW-1:0]   hi;
  } mid_t;

  typedef struct packed {
    mid_t           mid;
    logic [LW-1:0]  len;
  } sq_t;

  typedef struct packed {
    mid_t               mid;
    logic [2:0][QTW-1:0] q;
  } dv_t;

  // clamp a working value to the signed coordinate range
  function automatic logic [CW-1:0] sat_coord(input logic [EW-1:0] v);
    logic [CW-1:0] r;
    if ($signed(v) > CMAX) begin
      r = CMAX[CW-1:0];
    end else if ($signed(v) < CMIN) begin
      r = CMIN[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/capsule_support_and_bounds_top.sv =====
// Top level: capsule support point and bounding box pipeline with its register port.
//
// Takes one word per cycle while the output side does not stall and returns one result word
// per input, in order, through 7 front stages (axis, offset multiply, endpoints, dot product
// sign, direction normalize, squares), 31 square root stages (one length bit each), 34 divider
// stages (numerator multiply, then one quotient bit each) and the output register. Every
// stage holds its own valid bit and moves when the stage after it is empty or moving, so
// bubbles close up and a stalled output only backs up as far as the pipeline is full.
// radius and half_height are written through cfg_we/cfg_index/cfg_wdata, reset to 1.0,
// and are read directly by the offset multiply and the divider and output stages.
module capsule_support_and_bounds_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cap_pkg::in_t            in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output cap_pkg::out_t           out_data,
  input  logic                    cfg_we,
  input  logic [cap_pkg::CIW-1:0] cfg_index,
  input  logic [cap_pkg::RW-1:0]  cfg_wdata
);

  // configuration registers
  logic [cap_pkg::RW-1:0] radius_r, half_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= cap_pkg::RADIUS_RST;
      half_height_r <= cap_pkg::HALF_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cap_pkg::REG_RADIUS:      radius_r      <= cfg_wdata;
        cap_pkg::REG_HALF_HEIGHT: half_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic          m_valid, m_ready, s_valid, s_ready, d_valid, d_ready;
  cap_pkg::mid_t m_data;
  cap_pkg::sq_t  s_data;
  cap_pkg::dv_t  d_data;

  cap_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .half_height(half_height_r),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_data     (m_data)
  );

  cap_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_valid(m_valid),
    .i_ready(m_ready),
    .i_data (m_data),
    .o_valid(s_valid),
    .o_ready(s_ready),
    .o_data (s_data)
  );

  cap_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_valid(s_valid),
    .i_ready(s_ready),
    .i_data (s_data),
    .radius (radius_r),
    .o_valid(d_valid),
    .o_ready(d_ready),
    .o_data (d_data)
  );

  cap_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .i_valid  (d_valid),
    .i_ready  (d_ready),
    .i_data   (d_data),
    .radius   (radius_r),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // input backs up only when a finished word is waiting at the output
  a_full_only_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no word at the output");

endmodule

// ===== src/cap_front.sv =====
// Front pipeline: axis, endpoint offset, box, endpoint choice, direction normalize, sum of squares.
module cap_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cap_pkg::in_t       in_data,
  input  logic [cap_pkg::RW-1:0] half_height,
  output logic               m_valid,
  input  logic               m_ready,
  output cap_pkg::mid_t      m_data
);

  localparam int NS       = 7;
  localparam int PB       = $clog2(cap_pkg::CW);
  localparam int NORM_TOP = cap_pkg::NW - 1;
  localparam int PLW      = cap_pkg::OFW + cap_pkg::DLO + 1;
  localparam int PHW      = cap_pkg::OFW + cap_pkg::DHW;
  localparam int SLW      = PLW + 2;
  localparam int SHW      = PHW + 2;

  // stage valids and ready chain
  logic [NS:1]   v_r;
  logic [NS+1:1] rdy;
  logic [NS:1]   v_in;

  assign v_in = {v_r[NS-1:1], in_valid};

  always_comb begin
    rdy[NS+1] = m_ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[1];
  assign m_valid  = v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // stage 1: quaternion products
  logic signed [2*cap_pkg::QW-1:0] s1_xy_r, s1_wz_r, s1_xx_r, s1_zz_r, s1_wx_r, s1_yz_r;
  logic [2:0][cap_pkg::CW-1:0]     s1_pos_r, s1_dir_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_xy_r  <= in_data.quat_x * in_data.quat_y;
      s1_wz_r  <= in_data.quat_w * in_data.quat_z;
      s1_xx_r  <= in_data.quat_x * in_data.quat_x;
      s1_zz_r  <= in_data.quat_z * in_data.quat_z;
      s1_wx_r  <= in_data.quat_w * in_data.quat_x;
      s1_yz_r  <= in_data.quat_y * in_data.quat_z;
      s1_pos_r <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
      s1_dir_r <= {in_data.dir_z, in_data.dir_y, in_data.dir_x};
    end
  end

  // stage 2: axis in Q.28, direction magnitudes
  logic [2:0][cap_pkg::AXW-1:0] s2_ax_nxt, s2_ax_r;
  logic [2:0][cap_pkg::CW-1:0]  s2_e_nxt, s2_e_r, s2_pos_r, s2_dir_r;

  always_comb begin
    s2_ax_nxt[0] = (cap_pkg::AXW'(s1_xy_r) - cap_pkg::AXW'(s1_wz_r)) << 1;
    s2_ax_nxt[1] = cap_pkg::AX_ONE - ((cap_pkg::AXW'(s1_xx_r) + cap_pkg::AXW'(s1_zz_r)) << 1);
    s2_ax_nxt[2] = (cap_pkg::AXW'(s1_wx_r) + cap_pkg::AXW'(s1_yz_r)) << 1;
    for (int i = 0; i < 3; i++) begin
      s2_e_nxt[i] = s1_dir_r[i][cap_pkg::CW-1] ? (~s1_dir_r[i] + 1'b1) : s1_dir_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_ax_r  <= s2_ax_nxt;
      s2_e_r   <= s2_e_nxt;
      s2_pos_r <= s1_pos_r;
      s2_dir_r <= s1_dir_r;
    end
  end

  // stage 3: offset = half_height * axis rounded to Q16.16, largest magnitude
  logic [2:0][cap_pkg::OFW-1:0] s3_off_nxt, s3_off_r;
  logic [cap_pkg::CW-1:0]       s3_m_nxt, s3_m_r;
  logic [2:0][cap_pkg::CW-1:0]  s3_e_r, s3_pos_r, s3_dir_r;

  always_comb begin
    logic [cap_pkg::AXW-1:0] amag;
    logic [cap_pkg::PRW-1:0] pr;
    logic [cap_pkg::OFW-1:0] offm;
    for (int i = 0; i < 3; i++) begin
      amag = s2_ax_r[i][cap_pkg::AXW-1] ? (~s2_ax_r[i] + 1'b1) : s2_ax_r[i];
      pr   = cap_pkg::PRW'(half_height) * cap_pkg::PRW'(amag[cap_pkg::AMW-1:0])
             + cap_pkg::OFF_RND;
      offm = pr[cap_pkg::PRW-1:cap_pkg::AX_FRAC];
      s3_off_nxt[i] = s2_ax_r[i][cap_pkg::AXW-1] ? (~offm + 1'b1) : offm;
    end
    s3_m_nxt = s2_e_r[0];
    if (s2_e_r[1] > s3_m_nxt) s3_m_nxt = s2_e_r[1];
    if (s2_e_r[2] > s3_m_nxt) s3_m_nxt = s2_e_r[2];
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_off_r <= s3_off_nxt;
      s3_m_r   <= s3_m_nxt;
      s3_e_r   <= s2_e_r;
      s3_pos_r <= s2_pos_r;
      s3_dir_r <= s2_dir_r;
    end
  end

  // stage 4: endpoints, dot partial products, leading one of the magnitude
  logic [PB-1:0]                s4_p_nxt, s4_p_r;
  logic                         s4_zero_r;
  logic [2:0][cap_pkg::EW-1:0]  s4_top_nxt, s4_bot_nxt, s4_top_r, s4_bot_r;
  logic [2:0][PLW-1:0]          s4_plo_nxt, s4_plo_r;
  logic [2:0][PHW-1:0]          s4_phi_nxt, s4_phi_r;
  logic [2:0][cap_pkg::CW-1:0]  s4_e_r;
  logic [2:0]                   s4_neg_r;

  always_comb begin
    s4_p_nxt = '0;
    for (int j = 0; j < cap_pkg::CW; j++) begin
      if (s3_m_r[j]) s4_p_nxt = PB'(j);
    end
    for (int i = 0; i < 3; i++) begin
      s4_top_nxt[i] = cap_pkg::EW'($signed(s3_pos_r[i])) + cap_pkg::EW'($signed(s3_off_r[i]));
      s4_bot_nxt[i] = cap_pkg::EW'($signed(s3_pos_r[i])) - cap_pkg::EW'($signed(s3_off_r[i]));
      s4_plo_nxt[i] = $signed(s3_off_r[i]) *
                      $signed({1'b0, s3_dir_r[i][cap_pkg::DLO-1:0]});
      s4_phi_nxt[i] = $signed(s3_off_r[i]) *
                      $signed(s3_dir_r[i][cap_pkg::CW-1:cap_pkg::DLO]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_p_r    <= s4_p_nxt;
      s4_zero_r <= (s3_m_r == '0);
      s4_top_r  <= s4_top_nxt;
      s4_bot_r  <= s4_bot_nxt;
      s4_plo_r  <= s4_plo_nxt;
      s4_phi_r  <= s4_phi_nxt;
      s4_e_r    <= s3_e_r;
      s4_neg_r  <= {s3_dir_r[2][cap_pkg::CW-1], s3_dir_r[1][cap_pkg::CW-1],
                    s3_dir_r[0][cap_pkg::CW-1]};
    end
  end

  // stage 5: normalize direction, partial dot sums, box extents
  logic [2:0][cap_pkg::NW-1:0]  s5_en_nxt, s5_en_r;
  logic [SLW-1:0]               s5_slo_nxt, s5_slo_r;
  logic [SHW-1:0]               s5_shi_nxt, s5_shi_r;
  logic [2:0][cap_pkg::EW-1:0]  s5_lo_nxt, s5_hi_nxt, s5_lo_r, s5_hi_r, s5_top_r, s5_bot_r;
  logic [2:0]                   s5_neg_r;
  logic                         s5_zero_r;

  always_comb begin
    logic [cap_pkg::CW+cap_pkg::NW-1:0] x;
    for (int i = 0; i < 3; i++) begin
      x = (cap_pkg::CW + cap_pkg::NW)'(s4_e_r[i]);
      if (int'(s4_p_r) > NORM_TOP) begin
        x = x >> (int'(s4_p_r) - NORM_TOP);
      end else begin
        x = x << (NORM_TOP - int'(s4_p_r));
      end
      s5_en_nxt[i] = x[cap_pkg::NW-1:0];
      if ($signed(s4_top_r[i]) < $signed(s4_bot_r[i])) begin
        s5_lo_nxt[i] = s4_top_r[i];
        s5_hi_nxt[i] = s4_bot_r[i];
      end else begin
        s5_lo_nxt[i] = s4_bot_r[i];
        s5_hi_nxt[i] = s4_top_r[i];
      end
    end
    s5_slo_nxt = SLW'($signed(s4_plo_r[0])) + SLW'($signed(s4_plo_r[1]))
               + SLW'($signed(s4_plo_r[2]));
    s5_shi_nxt = SHW'($signed(s4_phi_r[0])) + SHW'($signed(s4_phi_r[1]))
               + SHW'($signed(s4_phi_r[2]));
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_en_r   <= s5_en_nxt;
      s5_slo_r  <= s5_slo_nxt;
      s5_shi_r  <= s5_shi_nxt;
      s5_lo_r   <= s5_lo_nxt;
      s5_hi_r   <= s5_hi_nxt;
      s5_top_r  <= s4_top_r;
      s5_bot_r  <= s4_bot_r;
      s5_neg_r  <= s4_neg_r;
      s5_zero_r <= s4_zero_r;
    end
  end

  // stage 6: squares, full dot product sign, endpoint pick
  logic [2:0][2*cap_pkg::NW-1:0] s6_sq_nxt, s6_sq_r;
  logic [cap_pkg::DTW-1:0]       s6_dot;
  logic [2:0][cap_pkg::EW-1:0]   s6_pt_nxt, s6_pt_r, s6_lo_r, s6_hi_r;
  logic [2:0][cap_pkg::NW-1:0]   s6_en_r;
  logic [2:0]                    s6_neg_r;
  logic                          s6_zero_r;
  logic                          s6_pick;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_sq_nxt[i] = (2*cap_pkg::NW)'(s5_en_r[i]) * (2*cap_pkg::NW)'(s5_en_r[i]);
    end
    s6_dot  = (cap_pkg::DTW'($signed(s5_shi_r)) << cap_pkg::DLO)
            + cap_pkg::DTW'($signed(s5_slo_r));
    // top endpoint only on a strictly positive dot product
    s6_pick = !s6_dot[cap_pkg::DTW-1] && (s6_dot != '0);
    for (int i = 0; i < 3; i++) begin
      s6_pt_nxt[i] = s6_pick ? s5_top_r[i] : s5_bot_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_sq_r   <= s6_sq_nxt;
      s6_pt_r   <= s6_pt_nxt;
      s6_lo_r   <= s5_lo_r;
      s6_hi_r   <= s5_hi_r;
      s6_en_r   <= s5_en_r;
      s6_neg_r  <= s5_neg_r;
      s6_zero_r <= s5_zero_r;
    end
  end

  // stage 7: sum of squares
  cap_pkg::mid_t s7_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_r.sum  <= cap_pkg::SQW'(s6_sq_r[0]) + cap_pkg::SQW'(s6_sq_r[1])
                 + cap_pkg::SQW'(s6_sq_r[2]);
      s7_r.e    <= s6_en_r;
      s7_r.neg  <= s6_neg_r;
      s7_r.zero <= s6_zero_r;
      s7_r.pt   <= s6_pt_r;
      s7_r.lo   <= s6_lo_r;
      s7_r.hi   <= s6_hi_r;
    end
  end

  assign m_data = s7_r;

  // a nonzero direction is normalized so its largest component has the top bit set
  a_norm_top: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && !s5_zero_r) |->
      (s5_en_r[0][cap_pkg::NW-1] || s5_en_r[1][cap_pkg::NW-1] || s5_en_r[2][cap_pkg::NW-1]))
    else $error("normalized direction out of range");

endmodule

// ===== src/cap_sqrt.sv =====
// Pipelined integer square root of the direction length, one result bit per stage.
module cap_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          i_valid,
  output logic          i_ready,
  input  cap_pkg::mid_t i_data,
  output logic          o_valid,
  input  logic          o_ready,
  output cap_pkg::sq_t  o_data
);

  localparam int NS  = cap_pkg::LW;
  localparam int SQW = cap_pkg::SQW;
  localparam int RMW = cap_pkg::RMW;
  localparam int LW  = cap_pkg::LW;

  logic [NS-1:0]   v_r;
  logic [NS:0]     rdy;
  logic [SQW-1:0]  rad_r  [NS];
  logic [RMW-1:0]  rem_r  [NS];
  logic [LW-1:0]   root_r [NS];
  cap_pkg::mid_t   mid_r  [NS];

  assign rdy[NS]  = o_ready;
  assign i_ready  = rdy[0];
  assign o_valid  = v_r[NS-1];
  assign o_data.mid = mid_r[NS-1];
  assign o_data.len = root_r[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic [SQW-1:0] rad_p;
    logic [RMW-1:0] rem_p;
    logic [LW-1:0]  root_p;
    cap_pkg::mid_t  mid_p;
    logic           v_p;
    logic [RMW-1:0] rem_t, trial, rem_nxt;
    logic [LW-1:0]  root_nxt;

    if (k == 0) begin : g_head
      assign rad_p  = i_data.sum;
      assign rem_p  = '0;
      assign root_p = '0;
      assign mid_p  = i_data;
      assign v_p    = i_valid;
    end else begin : g_body
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign mid_p  = mid_r[k-1];
      assign v_p    = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    // bring down the next bit pair, try root*4+1
    always_comb begin
      rem_t = {rem_p[RMW-3:0], rad_p[SQW-1:SQW-2]};
      trial = RMW'({root_p, 2'b01});
      if (rem_t >= trial) begin
        rem_nxt  = rem_t - trial;
        root_nxt = {root_p[LW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t;
        root_nxt = {root_p[LW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rad_r[k]  <= rad_p << 2;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        mid_r[k]  <= mid_p;
      end
    end
  end

  // the root leaving the pipe is the floor square root of its sum
  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] |->
      ((64'(root_r[NS-1]) * 64'(root_r[NS-1]) <= 64'(mid_r[NS-1].sum)) &&
       ((64'(root_r[NS-1]) + 64'd1) * (64'(root_r[NS-1]) + 64'd1) > 64'(mid_r[NS-1].sum))))
    else $error("square root result off");

endmodule

// ===== src/cap_div.sv =====
// Radial offset: radius*e/len rounded, three restoring dividers in lockstep.
module cap_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   i_valid,
  output logic                   i_ready,
  input  cap_pkg::sq_t           i_data,
  input  logic [cap_pkg::RW-1:0] radius,
  output logic                   o_valid,
  input  logic                   o_ready,
  output cap_pkg::dv_t           o_data
);

  localparam int QTW  = cap_pkg::QTW;
  localparam int NS   = QTW + 1;
  localparam int NUMW = cap_pkg::NUMW;
  localparam int DRW  = cap_pkg::DRW;
  localparam int LW   = cap_pkg::LW;

  logic [NS-1:0]         v_r;
  logic [NS:0]           rdy;
  logic [2:0][NUMW-1:0]  n_r   [NS];
  logic [2:0][DRW-1:0]   rem_r [NS];
  logic [2:0][QTW-1:0]   q_r   [NS];
  logic [LW-1:0]         len_r [NS];
  cap_pkg::mid_t         mid_r [NS];

  assign rdy[NS]    = o_ready;
  assign i_ready    = rdy[0];
  assign o_valid    = v_r[NS-1];
  assign o_data.mid = mid_r[NS-1];
  assign o_data.q   = q_r[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic                 v_p;
    logic [2:0][NUMW-1:0] n_nxt;
    logic [2:0][DRW-1:0]  rem_nxt;
    logic [2:0][QTW-1:0]  q_nxt;
    logic [LW-1:0]        len_p;
    cap_pkg::mid_t        mid_p;

    assign rdy[k] = !v_r[k] || rdy[k+1];

    if (k == 0) begin : g_head
      // numerator radius*e + len/2; remainder seeded with its top bits
      assign v_p   = i_valid;
      assign len_p = i_data.len;
      assign mid_p = i_data.mid;
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          n_nxt[i]   = NUMW'(radius) * NUMW'(i_data.mid.e[i]) + NUMW'(i_data.len >> 1);
          rem_nxt[i] = DRW'(n_nxt[i][NUMW-1:QTW]);
          q_nxt[i]   = '0;
        end
      end
    end else begin : g_body
      localparam int B = QTW - k;
      logic [DRW-1:0] rem_t;
      assign v_p   = v_r[k-1];
      assign len_p = len_r[k-1];
      assign mid_p = mid_r[k-1];
      // one quotient bit per lane
      always_comb begin
        rem_t = '0;
        for (int i = 0; i < 3; i++) begin
          n_nxt[i] = n_r[k-1][i];
          rem_t    = {rem_r[k-1][i][DRW-2:0], n_r[k-1][i][B]};
          if (rem_t >= DRW'(len_r[k-1])) begin
            rem_nxt[i] = rem_t - DRW'(len_r[k-1]);
            q_nxt[i]   = {q_r[k-1][i][QTW-2:0], 1'b1};
          end else begin
            rem_nxt[i] = rem_t;
            q_nxt[i]   = {q_r[k-1][i][QTW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        n_r[k]   <= n_nxt;
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        len_r[k] <= len_p;
        mid_r[k] <= mid_p;
      end
    end
  end

  // a finished division of a nonzero direction leaves a remainder below the divisor in every lane
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && !mid_r[NS-1].zero) |->
      ((rem_r[NS-1][0] < DRW'(len_r[NS-1])) && (rem_r[NS-1][1] < DRW'(len_r[NS-1])) &&
       (rem_r[NS-1][2] < DRW'(len_r[NS-1]))))
    else $error("divider remainder not reduced");

endmodule

// ===== src/cap_back.sv =====
// Output stage: add radial offset, widen box by radius, saturate, output register.
module cap_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   i_valid,
  output logic                   i_ready,
  input  cap_pkg::dv_t           i_data,
  input  logic [cap_pkg::RW-1:0] radius,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cap_pkg::out_t          out_data
);

  logic                         out_valid_r;
  cap_pkg::out_t                out_data_r, out_nxt;
  logic                         rdy;
  logic [2:0][cap_pkg::CW-1:0]  sup, bmin, bmax;

  assign rdy       = !out_valid_r || out_ready;
  assign i_ready   = rdy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // final sums and clamping
  always_comb begin
    logic [cap_pkg::EW-1:0] qx, rad;
    for (int i = 0; i < 3; i++) begin
      qx = cap_pkg::EW'(i_data.q[i]);
      if (i_data.mid.zero) begin
        rad = '0;
      end else if (i_data.mid.neg[i]) begin
        rad = ~qx + 1'b1;
      end else begin
        rad = qx;
      end
      sup[i]  = cap_pkg::sat_coord(i_data.mid.pt[i] + rad);
      bmin[i] = cap_pkg::sat_coord(i_data.mid.lo[i] - cap_pkg::EW'(radius));
      bmax[i] = cap_pkg::sat_coord(i_data.mid.hi[i] + cap_pkg::EW'(radius));
    end
    out_nxt.support_x      = sup[0];
    out_nxt.support_y      = sup[1];
    out_nxt.support_z      = sup[2];
    out_nxt.box_min_x      = bmin[0];
    out_nxt.box_min_y      = bmin[1];
    out_nxt.box_min_z      = bmin[2];
    out_nxt.box_max_x      = bmax[0];
    out_nxt.box_max_y      = bmax[1];
    out_nxt.box_max_z      = bmax[2];
    out_nxt.zero_direction = i_data.mid.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy) begin
      out_valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      out_data_r <= out_nxt;
    end
  end

endmodule
